FILE: rtl/core/owm_pkg.sv
// ---------------------------------------------------------------------------
// owm_pkg
// Shared types and codes for the 1-Wire bus master byte engine.
// ---------------------------------------------------------------------------
`default_nettype none

package owm_pkg;

    // Command codes carried in the mode field
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_RESET = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // Sequencer phases
    localparam int unsigned PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_RST_LOW  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_RST_WAIT = 3'd2;
    localparam logic [PHASE_W-1:0] PH_RST_REC  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SLOT     = 3'd4;
    localparam logic [PHASE_W-1:0] PH_W_HOLD   = 3'd5;
    localparam logic [PHASE_W-1:0] PH_R_WAIT   = 3'd6;
    localparam logic [PHASE_W-1:0] PH_R_REC    = 3'd7;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_REC     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_START    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_SLOT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_READ_REC      = 3'd6;

    // Timing register reset values
    localparam logic [9:0] RESET_LOW_DEFAULT     = 10'd480;
    localparam logic [7:0] PRESENCE_WAIT_DEFAULT = 8'd60;
    localparam logic [9:0] RESET_REC_DEFAULT     = 10'd420;
    localparam logic [3:0] SLOT_START_DEFAULT    = 4'd1;
    localparam logic [7:0] WRITE_SLOT_DEFAULT    = 8'd60;
    localparam logic [7:0] READ_SAMPLE_DEFAULT   = 8'd14;
    localparam logic [7:0] READ_REC_DEFAULT      = 8'd45;

    localparam int unsigned TICK_W = 10;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] write_byte;
        logic       line_in;
    } owm_in_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       no_presence;
        logic [7:0] read_data;
    } owm_out_t;

endpackage

`default_nettype wire

FILE: rtl/core/onewire_master_byte_engine.sv
// ---------------------------------------------------------------------------
// onewire_master_byte_engine
// 1-Wire bus master running reset, write-byte and read-byte sequences.
// ---------------------------------------------------------------------------
// Each input transfer is one bus timing tick (normally one microsecond) and
// carries an optional command plus the bus level sampled in that tick; each
// tick yields exactly one output transfer with the drive level, busy/done
// flags, the last presence result and the last byte read. The engine takes
// one transfer per clock cycle while the output side does not stall: a tick
// lands in the input register, and the phase sequencer advances and loads
// the result register once that register is free or draining. The output
// register keeps results flowing while a new tick waits in the input
// register; input stall only rises when both stages are full and the output
// side stalls. Commands are honored only while idle. Timing registers may
// be written only while the engine is idle; a zero timing value acts as one.
// ---------------------------------------------------------------------------
`default_nettype none

module onewire_master_byte_engine (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // tick input channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire owm_pkg::owm_in_t                   in_data,
    // result output channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output owm_pkg::owm_out_t                       out_data,
    // configuration write port
    input  wire logic                               cfg_write_en,
    input  wire logic [owm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [owm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // -----------------------------------------------------------------
    // Timing registers
    // -----------------------------------------------------------------
    logic [9:0] reset_low_reg;
    logic [7:0] presence_wait_reg;
    logic [9:0] reset_rec_reg;
    logic [3:0] slot_start_reg;
    logic [7:0] write_slot_reg;
    logic [7:0] read_sample_reg;
    logic [7:0] read_rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_low_reg     <= owm_pkg::RESET_LOW_DEFAULT;
            presence_wait_reg <= owm_pkg::PRESENCE_WAIT_DEFAULT;
            reset_rec_reg     <= owm_pkg::RESET_REC_DEFAULT;
            slot_start_reg    <= owm_pkg::SLOT_START_DEFAULT;
            write_slot_reg    <= owm_pkg::WRITE_SLOT_DEFAULT;
            read_sample_reg   <= owm_pkg::READ_SAMPLE_DEFAULT;
            read_rec_reg      <= owm_pkg::READ_REC_DEFAULT;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                owm_pkg::REG_RESET_LOW:     reset_low_reg     <= cfg_data[9:0];
                owm_pkg::REG_PRESENCE_WAIT: presence_wait_reg <= cfg_data[7:0];
                owm_pkg::REG_RESET_REC:     reset_rec_reg     <= cfg_data[9:0];
                owm_pkg::REG_SLOT_START:    slot_start_reg    <= cfg_data[3:0];
                owm_pkg::REG_WRITE_SLOT:    write_slot_reg    <= cfg_data[7:0];
                owm_pkg::REG_READ_SAMPLE:   read_sample_reg   <= cfg_data[7:0];
                owm_pkg::REG_READ_REC:      read_rec_reg      <= cfg_data[7:0];
                default:                    ; // index past the register list: drop
            endcase
        end
    end

    // -----------------------------------------------------------------
    // Input register and pipeline handshake
    // -----------------------------------------------------------------
    logic             in_vld_reg;
    owm_pkg::owm_in_t in_data_reg;
    logic             out_vld_reg;
    owm_pkg::owm_out_t out_data_reg;
    logic             advance;

    // Process the held tick whenever the result register is free or draining.
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_data_reg <= in_data;
        end
    end

    // -----------------------------------------------------------------
    // Sequencer state
    // -----------------------------------------------------------------
    logic [owm_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [1:0]                  op_reg, op_next;
    logic [owm_pkg::TICK_W-1:0]  tick_reg, tick_next;
    logic [2:0]                  bit_reg, bit_next;
    logic [7:0]                  shift_reg, shift_next;
    logic                        presence_reg, presence_next;
    logic [7:0]                  last_read_reg, last_read_next;

    // Effective state for this tick once a command start is folded in
    logic                        start;
    logic [owm_pkg::PHASE_W-1:0] ph_cur;
    logic [1:0]                  op_cur;
    logic [owm_pkg::TICK_W-1:0]  tick_cur;
    logic [2:0]                  bit_cur;
    logic [7:0]                  shift_cur;

    logic [owm_pkg::TICK_W-1:0]  phase_len;
    logic                        last_tick;
    logic                        drive;
    logic                        busy;
    logic                        done;

    // A command only starts from idle; it runs its first tick right away.
    assign start     = (phase_reg == owm_pkg::PH_IDLE) &&
                       (in_data_reg.mode != owm_pkg::MODE_TICK);
    assign ph_cur    = start ? ((in_data_reg.mode == owm_pkg::MODE_RESET) ?
                                owm_pkg::PH_RST_LOW : owm_pkg::PH_SLOT)
                             : phase_reg;
    assign op_cur    = start ? in_data_reg.mode : op_reg;
    assign tick_cur  = start ? '0 : tick_reg;
    assign bit_cur   = start ? 3'd0 : bit_reg;
    assign shift_cur = start ? ((in_data_reg.mode == owm_pkg::MODE_WRITE) ?
                                in_data_reg.write_byte : 8'd0)
                             : shift_reg;

    // Length of the current phase in ticks, zero settings count as one.
    always_comb
    begin
        phase_len = 10'd1;
        unique case (ph_cur)
            owm_pkg::PH_RST_LOW:  phase_len = reset_low_reg;
            owm_pkg::PH_RST_WAIT: phase_len = {2'b00, presence_wait_reg};
            owm_pkg::PH_RST_REC:  phase_len = reset_rec_reg;
            owm_pkg::PH_SLOT:     phase_len = {6'd0, slot_start_reg};
            owm_pkg::PH_W_HOLD:   phase_len = {2'b00, write_slot_reg};
            owm_pkg::PH_R_WAIT:   phase_len = {2'b00, read_sample_reg};
            owm_pkg::PH_R_REC:    phase_len = {2'b00, read_rec_reg};
            default:              phase_len = 10'd1;
        endcase
        if (phase_len == '0)
        begin
            phase_len = 10'd1;
        end
    end

    assign last_tick = ({1'b0, tick_cur} + 11'd1) >= {1'b0, phase_len};
    assign busy      = (ph_cur != owm_pkg::PH_IDLE);

    // Bus drive: low during reset pulse and slot opening; a write slot holds
    // low through its body only for a zero bit.
    always_comb
    begin
        case (ph_cur) inside
            owm_pkg::PH_RST_LOW, owm_pkg::PH_SLOT: drive = 1'b1;
            owm_pkg::PH_W_HOLD:                    drive = ~shift_cur[0];
            default:                               drive = 1'b0;
        endcase
    end

    // Phase transitions at the last tick of each phase
    always_comb
    begin
        phase_next     = ph_cur;
        op_next        = op_cur;
        tick_next      = tick_cur;
        bit_next       = bit_cur;
        shift_next     = shift_cur;
        presence_next  = presence_reg;
        last_read_next = last_read_reg;
        done           = 1'b0;

        if (busy)
        begin
            if (last_tick)
            begin
                tick_next = '0;
                unique case (ph_cur)
                    owm_pkg::PH_RST_LOW:
                    begin
                        phase_next = owm_pkg::PH_RST_WAIT;
                    end
                    owm_pkg::PH_RST_WAIT:
                    begin
                        presence_next = in_data_reg.line_in;
                        phase_next    = owm_pkg::PH_RST_REC;
                    end
                    owm_pkg::PH_RST_REC:
                    begin
                        done       = 1'b1;
                        phase_next = owm_pkg::PH_IDLE;
                    end
                    owm_pkg::PH_SLOT:
                    begin
                        phase_next = (op_cur == owm_pkg::MODE_WRITE) ?
                                     owm_pkg::PH_W_HOLD : owm_pkg::PH_R_WAIT;
                    end
                    owm_pkg::PH_W_HOLD:
                    begin
                        shift_next = {1'b0, shift_cur[7:1]};
                        if (bit_cur == 3'd7)
                        begin
                            done       = 1'b1;
                            phase_next = owm_pkg::PH_IDLE;
                        end
                        else
                        begin
                            bit_next   = bit_cur + 3'd1;
                            phase_next = owm_pkg::PH_SLOT;
                        end
                    end
                    owm_pkg::PH_R_WAIT:
                    begin
                        // Shift the sampled bit in from the top, LSB first.
                        shift_next = {in_data_reg.line_in, shift_cur[7:1]};
                        phase_next = owm_pkg::PH_R_REC;
                    end
                    owm_pkg::PH_R_REC:
                    begin
                        if (bit_cur == 3'd7)
                        begin
                            last_read_next = shift_cur;
                            done           = 1'b1;
                            phase_next     = owm_pkg::PH_IDLE;
                        end
                        else
                        begin
                            bit_next   = bit_cur + 3'd1;
                            phase_next = owm_pkg::PH_SLOT;
                        end
                    end
                    default:
                    begin
                        phase_next = owm_pkg::PH_IDLE;
                    end
                endcase
            end
            else
            begin
                tick_next = tick_cur + 10'd1;
            end
        end
    end

    // Advance state only when the tick is actually consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= owm_pkg::PH_IDLE;
            op_reg        <= owm_pkg::MODE_TICK;
            tick_reg      <= '0;
            bit_reg       <= 3'd0;
            shift_reg     <= 8'd0;
            presence_reg  <= 1'b0;
            last_read_reg <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            op_reg        <= op_next;
            tick_reg      <= tick_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            presence_reg  <= presence_next;
            last_read_reg <= last_read_next;
        end
    end

    // -----------------------------------------------------------------
    // Result register
    // -----------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg.drive_low   <= drive;
            out_data_reg.busy_res    <= busy;
            out_data_reg.done_res    <= done;
            out_data_reg.no_presence <= presence_next;
            out_data_reg.read_data   <= last_read_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/owm_checker.sv
// ---------------------------------------------------------------------------
// owm_checker
// Port-level checks for the 1-Wire bus master byte engine.
// ---------------------------------------------------------------------------
`default_nettype none

module owm_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_stall,
    input  wire owm_pkg::owm_in_t                   in_data,
    input  wire logic                               out_valid,
    input  wire logic                               out_stall,
    input  wire owm_pkg::owm_out_t                  out_data
);

    // Hold a stalled tick steady until the engine takes it.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("stalled tick changed");

    // Hold a stalled result steady.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // Input stalls only when the result register is full and blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // Done marks the last tick of an operation, so busy is up with it.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res |-> out_data.busy_res)
        else $error("done without busy");

    // Release the bus whenever no operation runs.
    a_idle_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.busy_res |-> !out_data.drive_low)
        else $error("bus driven while idle");

endmodule

bind onewire_master_byte_engine owm_checker u_owm_checker (.*);

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: 1-Wire bus master byte engine testbench
// Feeds microsecond ticks with commands and bus levels into the engine and
// compares every result transfer with a tick-by-tick software copy of the
// reset, write-byte and read-byte sequencer, across several timing settings.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycle budget for the whole run; the slowest legal run stays well below.
    localparam int unsigned CYCLE_LIMIT = 100_000;
    // Index past the last timing register; the engine must ignore it.
    localparam logic [owm_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int unsigned NUM_REGS = 7;

    typedef logic [owm_pkg::CFG_DATA_W-1:0] cfg_word_t;
    typedef logic [owm_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
    typedef cfg_word_t timing_set_t [NUM_REGS];
    typedef enum {LINE_LOW, LINE_HIGH, LINE_RANDOM} line_pattern_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the sequencer state tick by tick and holds the
    // results the engine owes us, oldest first.
    // ------------------------------------------------------------------------
    class bus_master_scoreboard;
        // timing registers
        logic [9:0] reset_low;
        logic [7:0] presence_wait;
        logic [9:0] reset_rec;
        logic [3:0] slot_start;
        logic [7:0] write_slot;
        logic [7:0] read_sample;
        logic [7:0] read_rec;
        // sequencer state
        logic [owm_pkg::PHASE_W-1:0] seq_phase;
        logic [1:0]                  cur_op;
        int unsigned                 tick_cnt;
        logic [2:0]                  bit_idx;
        logic [7:0]                  shifter;
        logic                        presence;
        logic [7:0]                  last_byte;

        owm_pkg::owm_out_t pending_results[$];
        int unsigned mismatches;
        int unsigned results_checked;
        int unsigned resets_run, writes_run, reads_run;

        function new();
            reset_low     = owm_pkg::RESET_LOW_DEFAULT;
            presence_wait = owm_pkg::PRESENCE_WAIT_DEFAULT;
            reset_rec     = owm_pkg::RESET_REC_DEFAULT;
            slot_start    = owm_pkg::SLOT_START_DEFAULT;
            write_slot    = owm_pkg::WRITE_SLOT_DEFAULT;
            read_sample   = owm_pkg::READ_SAMPLE_DEFAULT;
            read_rec      = owm_pkg::READ_REC_DEFAULT;
            seq_phase     = owm_pkg::PH_IDLE;
            cur_op        = owm_pkg::MODE_TICK;
            tick_cnt      = 0;
            bit_idx       = '0;
            shifter       = '0;
            presence      = 1'b0;
            last_byte     = '0;
            mismatches      = 0;
            results_checked = 0;
            resets_run = 0;
            writes_run = 0;
            reads_run  = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, cfg_word_t val);
            case (idx)
                owm_pkg::REG_RESET_LOW:     reset_low     = val;
                owm_pkg::REG_PRESENCE_WAIT: presence_wait = val[7:0];
                owm_pkg::REG_RESET_REC:     reset_rec     = val;
                owm_pkg::REG_SLOT_START:    slot_start    = val[3:0];
                owm_pkg::REG_WRITE_SLOT:    write_slot    = val[7:0];
                owm_pkg::REG_READ_SAMPLE:   read_sample   = val[7:0];
                owm_pkg::REG_READ_REC:      read_rec      = val[7:0];
                default: ;
            endcase
        endfunction

        function bit is_idle();
            return seq_phase == owm_pkg::PH_IDLE;
        endfunction

        // Length of a phase in ticks; a zero register stretches to one tick.
        function int unsigned phase_span(logic [owm_pkg::PHASE_W-1:0] ph);
            int unsigned v;
            case (ph)
                owm_pkg::PH_RST_LOW:  v = 32'(reset_low);
                owm_pkg::PH_RST_WAIT: v = 32'(presence_wait);
                owm_pkg::PH_RST_REC:  v = 32'(reset_rec);
                owm_pkg::PH_SLOT:     v = 32'(slot_start);
                owm_pkg::PH_W_HOLD:   v = 32'(write_slot);
                owm_pkg::PH_R_WAIT:   v = 32'(read_sample);
                owm_pkg::PH_R_REC:    v = 32'(read_rec);
                default:              v = 1;
            endcase
            return (v == 0) ? 1 : v;
        endfunction

        function owm_pkg::owm_out_t predict_tick(owm_pkg::owm_in_t t);
            owm_pkg::owm_out_t r;
            r = '0;
            // Start a command only from idle; drop it otherwise.
            if (seq_phase == owm_pkg::PH_IDLE && t.mode != owm_pkg::MODE_TICK) begin
                cur_op    = t.mode;
                tick_cnt  = 0;
                bit_idx   = '0;
                shifter   = (t.mode == owm_pkg::MODE_WRITE) ? t.write_byte : 8'h00;
                seq_phase = (t.mode == owm_pkg::MODE_RESET) ?
                            owm_pkg::PH_RST_LOW : owm_pkg::PH_SLOT;
                case (t.mode)
                    owm_pkg::MODE_RESET: resets_run++;
                    owm_pkg::MODE_WRITE: writes_run++;
                    default:             reads_run++;
                endcase
            end
            if (seq_phase != owm_pkg::PH_IDLE) begin
                r.busy_res = 1'b1;
                if (seq_phase == owm_pkg::PH_RST_LOW || seq_phase == owm_pkg::PH_SLOT)
                    r.drive_low = 1'b1;
                else if (seq_phase == owm_pkg::PH_W_HOLD)
                    r.drive_low = ~shifter[0];

                if (tick_cnt + 1 >= phase_span(seq_phase)) begin
                    tick_cnt = 0;
                    case (seq_phase)
                        owm_pkg::PH_RST_LOW:  seq_phase = owm_pkg::PH_RST_WAIT;
                        owm_pkg::PH_RST_WAIT: begin
                            presence  = t.line_in;
                            seq_phase = owm_pkg::PH_RST_REC;
                        end
                        owm_pkg::PH_RST_REC: begin
                            r.done_res = 1'b1;
                            seq_phase  = owm_pkg::PH_IDLE;
                        end
                        owm_pkg::PH_SLOT:
                            seq_phase = (cur_op == owm_pkg::MODE_WRITE) ?
                                        owm_pkg::PH_W_HOLD : owm_pkg::PH_R_WAIT;
                        owm_pkg::PH_W_HOLD: begin
                            shifter = shifter >> 1;
                            if (bit_idx == 3'd7) begin
                                r.done_res = 1'b1;
                                seq_phase  = owm_pkg::PH_IDLE;
                            end else begin
                                bit_idx   = bit_idx + 3'd1;
                                seq_phase = owm_pkg::PH_SLOT;
                            end
                        end
                        owm_pkg::PH_R_WAIT: begin
                            shifter   = {t.line_in, shifter[7:1]};
                            seq_phase = owm_pkg::PH_R_REC;
                        end
                        owm_pkg::PH_R_REC: begin
                            if (bit_idx == 3'd7) begin
                                last_byte  = shifter;
                                r.done_res = 1'b1;
                                seq_phase  = owm_pkg::PH_IDLE;
                            end else begin
                                bit_idx   = bit_idx + 3'd1;
                                seq_phase = owm_pkg::PH_SLOT;
                            end
                        end
                        default: seq_phase = owm_pkg::PH_IDLE;
                    endcase
                end else begin
                    tick_cnt++;
                end
            end
            r.no_presence = presence;
            r.read_data   = last_byte;
            return r;
        endfunction

        function void note_tick(owm_pkg::owm_in_t t);
            pending_results.push_back(predict_tick(t));
        endfunction

        task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
            mismatches++;
            if (mismatches <= 40)
                $display("[%0t] result %0d: %s got %0h, expected %0h",
                         $time, results_checked, what, got, want);
        endtask

        task check_result(owm_pkg::owm_out_t r);
            owm_pkg::owm_out_t e;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transfer, read_data", r.read_data, 8'h00);
                return;
            end
            e = pending_results.pop_front();
            if (r.drive_low !== e.drive_low)
                report_mismatch("drive_low", 8'(r.drive_low), 8'(e.drive_low));
            if (r.busy_res !== e.busy_res)
                report_mismatch("busy_res", 8'(r.busy_res), 8'(e.busy_res));
            if (r.done_res !== e.done_res)
                report_mismatch("done_res", 8'(r.done_res), 8'(e.done_res));
            if (r.no_presence !== e.no_presence)
                report_mismatch("no_presence", 8'(r.no_presence), 8'(e.no_presence));
            if (r.read_data !== e.read_data)
                report_mismatch("read_data", r.read_data, e.read_data);
            results_checked++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    owm_pkg::owm_in_t  in_data;
    logic              out_valid;
    logic              out_stall;
    owm_pkg::owm_out_t out_data;
    logic              cfg_write_en;
    cfg_idx_t          cfg_index;
    cfg_word_t         cfg_data;

    onewire_master_byte_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    bus_master_scoreboard sb = new();

    // Registers in index order, for the configuration loop.
    cfg_idx_t reg_order [NUM_REGS] = '{owm_pkg::REG_RESET_LOW,
        owm_pkg::REG_PRESENCE_WAIT, owm_pkg::REG_RESET_REC, owm_pkg::REG_SLOT_START,
        owm_pkg::REG_WRITE_SLOT, owm_pkg::REG_READ_SAMPLE, owm_pkg::REG_READ_REC};

    int unsigned cycle_count  = 0;
    int unsigned ticks_sent   = 0;
    int unsigned burst_left   = 0;
    int unsigned timing_sets  = 0;

    // ------------------------------------------------------------------------
    // Clock and cycle watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, sb.pending_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge. Note the accepted
    // tick first, then check any result leaving the engine in the same edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                sb.note_tick(in_data);
                ticks_sent++;
            end
            if (out_valid && !out_stall)
                sb.check_result(out_data);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver back-pressure: switch between a few stall styles, each held
    // for a random stretch, including stretches with no stall at all.
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned style;
        int unsigned span;
        int unsigned k;
        out_stall = 1'b0;
        forever
        begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(20, 200);
            for (k = 0; k < span; k++)
            begin
                @(negedge clk);
                case (style)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= (k % 5 == 0);
                    default: out_stall <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks. All of them start and end on a falling edge.
    // ------------------------------------------------------------------------

    // Present one tick and hold it until the engine takes the transfer.
    // The sender runs in bursts; open a new burst after a random gap.
    task automatic send_tick(input owm_pkg::owm_in_t t);
        int unsigned gap;
        int unsigned seen;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 60);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        seen = ticks_sent;
        // advance until the monitor has seen the transfer
        do
            @(negedge clk);
        while (ticks_sent == seen);
        burst_left--;
    endtask

    // Let any running operation finish, issue a command, then tick until
    // the operation has finished.
    task automatic run_op(input logic [1:0] cmd, input logic [7:0] byte_val,
                          input line_pattern_t pat);
        owm_pkg::owm_in_t t;
        t.mode       = owm_pkg::MODE_TICK;
        t.write_byte = byte_val;
        t.line_in    = (pat == LINE_HIGH) ? 1'b1 :
                       (pat == LINE_LOW)  ? 1'b0 : 1'($urandom_range(0, 1));
        while (!sb.is_idle())
            send_tick(t);
        t.mode = cmd;
        send_tick(t);
        t.mode = owm_pkg::MODE_TICK;
        while (!sb.is_idle())
        begin
            if (pat == LINE_RANDOM)
                t.line_in = 1'($urandom_range(0, 1));
            send_tick(t);
        end
    endtask

    // Finish any running operation, drop valid, wait for every owed result
    // and let the pipeline drain so the engine is quiet for register writes.
    task automatic settle();
        owm_pkg::owm_in_t t;
        t.mode = owm_pkg::MODE_TICK;
        while (!sb.is_idle())
        begin
            t.write_byte = 8'($urandom_range(0, 255));
            t.line_in    = 1'($urandom_range(0, 1));
            send_tick(t);
        end
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write all seven timing registers, one per cycle. Fill the bits above a
    // narrow register's width with noise; the engine must drop them. Close
    // with a write to the unused index, which must change nothing.
    task automatic apply_timing(input timing_set_t vals);
        cfg_word_t   word;
        int unsigned w;
        int unsigned i;
        for (i = 0; i < NUM_REGS; i++)
        begin
            case (reg_order[i])
                owm_pkg::REG_RESET_LOW, owm_pkg::REG_RESET_REC: w = 10;
                owm_pkg::REG_SLOT_START:                        w = 4;
                default:                                        w = 8;
            endcase
            word = cfg_word_t'(vals[i] & ((1 << w) - 1)) | cfg_word_t'($urandom() << w);
            cfg_write_en <= 1'b1;
            cfg_index    <= reg_order[i];
            cfg_data     <= word;
            sb.set_reg(reg_order[i], word);
            @(negedge clk);
        end
        word = cfg_word_t'($urandom_range(0, 1023));
        cfg_index <= REG_SPARE;
        cfg_data  <= word;
        sb.set_reg(REG_SPARE, word);
        @(negedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
        timing_sets++;
    endtask

    // Random timing set: every register up to lim ticks, zero included.
    task automatic apply_random_timing(input int unsigned lim);
        timing_set_t vals;
        int unsigned i;
        for (i = 0; i < NUM_REGS; i++)
            vals[i] = cfg_word_t'($urandom_range(0, lim));
        vals[3] = cfg_word_t'($urandom_range(0, (lim > 15) ? 15 : lim));
        apply_timing(vals);
    endtask

    // Random traffic. Mostly start commands when the engine is idle so the
    // sequencer keeps cycling; now and then throw a command at a busy engine.
    // Commands dropped by a busy engine do not count toward n.
    task automatic run_random(input int unsigned n);
        owm_pkg::owm_in_t t;
        int unsigned counted;
        bit idle_now;
        counted = 0;
        while (counted < n)
        begin
            idle_now     = sb.is_idle();
            t.write_byte = 8'($urandom_range(0, 255));
            t.line_in    = 1'($urandom_range(0, 1));
            if (idle_now)
                t.mode = ($urandom_range(0, 9) < 7) ?
                         2'($urandom_range(owm_pkg::MODE_RESET, owm_pkg::MODE_READ)) :
                         owm_pkg::MODE_TICK;
            else
                t.mode = ($urandom_range(0, 19) == 0) ?
                         2'($urandom_range(owm_pkg::MODE_RESET, owm_pkg::MODE_READ)) :
                         owm_pkg::MODE_TICK;
            if (idle_now || t.mode == owm_pkg::MODE_TICK)
                counted++;
            send_tick(t);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        owm_pkg::owm_in_t t;
        int unsigned i;

        // Hold every input at a known value through reset.
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_write_en = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Reset timing values: one full read byte over the default slot.
        run_op(owm_pkg::MODE_READ, 8'h00, LINE_RANDOM);
        settle();

        // Directed pass with every register at zero, which acts as one tick.
        apply_timing('{default: '0});
        run_op(owm_pkg::MODE_RESET, 8'hFF, LINE_HIGH);   // no device answers
        run_op(owm_pkg::MODE_RESET, 8'h00, LINE_LOW);    // presence pulse seen
        run_op(owm_pkg::MODE_WRITE, 8'h00, LINE_HIGH);
        run_op(owm_pkg::MODE_WRITE, 8'hFF, LINE_LOW);
        run_op(owm_pkg::MODE_READ, 8'h00, LINE_HIGH);    // read back all ones
        run_op(owm_pkg::MODE_READ, 8'hFF, LINE_LOW);     // read back all zeros
        // Idle ticks: flags low, presence and read byte hold.
        t.mode       = owm_pkg::MODE_TICK;
        t.write_byte = 8'hFF;
        t.line_in    = 1'b1;
        for (i = 0; i < 3; i++)
            send_tick(t);
        // The first write starts; the commands after it hit a busy engine
        // and must be dropped.
        t.mode       = owm_pkg::MODE_WRITE;
        t.write_byte = 8'h3C;
        send_tick(t);
        t.mode = owm_pkg::MODE_RESET;
        send_tick(t);
        t.mode = owm_pkg::MODE_READ;
        send_tick(t);
        t.mode       = owm_pkg::MODE_WRITE;
        t.write_byte = 8'hC3;
        send_tick(t);
        run_op(owm_pkg::MODE_RESET, 8'h00, LINE_HIGH);
        settle();

        // All registers at one tick, then random small timings.
        apply_timing('{default: 10'd1});
        run_random(60);
        settle();
        apply_random_timing(3);
        run_random(30);
        settle();
        apply_random_timing(6);
        run_random(30);
        settle();
        apply_random_timing(10);
        run_random(30);
        settle();

        // Longest reset pulse and longest slot opening, other phases short.
        apply_timing('{10'd1023, 10'd1, 10'd1, 10'd15, 10'd1, 10'd1, 10'd1});
        run_op(owm_pkg::MODE_RESET, 8'($urandom_range(0, 255)), LINE_RANDOM);
        settle();

        if (sb.pending_results.size() != 0)
            sb.report_mismatch("results never delivered",
                               8'(sb.pending_results.size()), 8'h00);

        $display("ran %0d resets, %0d byte writes and %0d byte reads over %0d timing sets",
                 sb.resets_run, sb.writes_run, sb.reads_run, timing_sets);
        $display("checked %0d result transfers in %0d cycles, %0d mismatches",
                 sb.results_checked, cycle_count, sb.mismatches);
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/owm_pkg.sv
rtl/core/onewire_master_byte_engine.sv
rtl/core/owm_checker.sv
dv/tb_top.sv
